// ===== hdl/stbs_pkg.sv =====
// Package for the sorted-table binary search unit.
// Holds payload structs, register indexes and sizing constants.
// No dependencies.
package stbs_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_DAT_W-1:0] ROW_WIDTH_RST   = CFG_DAT_W'(20);
  localparam logic [CFG_DAT_W-1:0] ENTRY_COUNT_RST = CFG_DAT_W'(256);

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Input item
  typedef struct packed {
    logic        req_type;
    logic [7:0]  entry_index;
    logic [15:0] key_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic       found;
    logic [7:0] found_index;
    logic [7:0] found_row;
    logic [7:0] found_col;
  } out_item_t;

endpackage

// ===== hdl/sorted_table_binary_search_unit.sv =====
// Sorted-table binary search unit: key table in a synchronous RAM,
// probe sequencer and bit-serial row/column divider. Uses stbs_pkg.
//
//  channel | ports                           | direction | transfer when
//  --------+---------------------------------+-----------+----------------------
//  in      | in_valid, in_stall, in_item     | input     | in_valid && !in_stall
//  out     | out_valid, out_stall, out_item  | output    | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_wdata    | input     | cfg_we
//
// A load writes the table RAM on its transfer. A search makes up to 9 probes,
// each a RAM read then a compare, then the empty-window check on a miss or
// the divider on a hit, and then hands the result to the output register.
// The input is stalled for the whole search and opens when the result is
// registered; a stalled result held in the output register delays this.
// The divider produces one quotient bit per cycle.
// Reset (rst_n, synchronous) clears control state and presets the configuration
// registers; table contents are undefined until loaded. A stalled result sits
// in the output register while the next item is accepted.
module sorted_table_binary_search_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stbs_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output stbs_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stbs_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  localparam int AW = stbs_pkg::ADDR_W;
  localparam int CW = stbs_pkg::CNT_W;
  localparam int KW = stbs_pkg::KEY_WIDTH;
  localparam int DW = stbs_pkg::CFG_DAT_W;
  localparam logic [CW-1:0] DEPTH = CW'(stbs_pkg::TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROBE = 5'b00010,
    S_CMP   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Key table
  logic [KW-1:0] table_mem [stbs_pkg::TABLE_DEPTH];

  state_t              state_r, state_nxt;
  logic [CW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [KW-1:0]       rd_data_r;
  logic                hit_r, hit_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [7:0]          quo_r, quo_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic [DW-1:0]       div_w_r, div_w_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [DW-1:0]       row_width_r, entry_count_r;
  logic                out_valid_r, out_valid_nxt;
  stbs_pkg::out_item_t out_item_r, out_item_nxt;

  logic                in_xfer, out_xfer, out_free;
  logic [CW-1:0]       span, mid_wide, count_sat;
  logic [DW-1:0]       trial, trial_sub;
  logic                trial_ge;
  logic                rd_en;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Window midpoint: lo + (hi - 1 - lo) / 2 over the half-open window [lo, hi)
  assign span     = hi_r - lo_r - CW'(1);
  assign mid_wide = lo_r + (span >> 1);

  // Covered entry count, saturated to the table depth
  assign count_sat = (entry_count_r > DW'(DEPTH)) ? DEPTH : CW'(entry_count_r);

  // Restoring divide step: partial remainder never exceeds 8 bits
  assign trial     = {rem_r, quo_r[7]};
  assign trial_ge  = (trial >= div_w_r);
  assign trial_sub = trial - div_w_r;

  assign rd_en = (state_r == S_PROBE) && (lo_r < hi_r);

  // Table RAM: write on load transfer, registered read on probe
  always_ff @(posedge clk) begin
    if (in_xfer && (in_item.req_type == stbs_pkg::REQ_LOAD)) begin
      table_mem[in_item.entry_index[AW-1:0]] <= in_item.key_value[KW-1:0];
    end
    if (rd_en) begin
      rd_data_r <= table_mem[mid_wide[AW-1:0]];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= stbs_pkg::ROW_WIDTH_RST;
      entry_count_r <= stbs_pkg::ENTRY_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == stbs_pkg::CFG_ROW_WIDTH) begin
        row_width_r <= cfg_wdata;
      end else if (cfg_index == stbs_pkg::CFG_ENTRY_COUNT) begin
        entry_count_r <= cfg_wdata;
      end
    end
  end

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_w_nxt     = div_w_r;
    step_nxt      = step_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_item.req_type == stbs_pkg::REQ_SEARCH)) begin
          key_nxt   = in_item.key_value[KW-1:0];
          lo_nxt    = '0;
          hi_nxt    = count_sat;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_wide[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          // window empty: miss, all position fields zero
          hit_nxt   = 1'b0;
          idx_nxt   = '0;
          quo_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        priority if (rd_data_r == key_r) begin
          hit_nxt   = 1'b1;
          idx_nxt   = 8'(mid_r);
          quo_nxt   = 8'(mid_r);
          rem_nxt   = '0;
          div_w_nxt = (row_width_r == '0) ? DW'(1) : row_width_r;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else if (rd_data_r < key_r) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = S_PROBE;
        end else begin
          hi_nxt    = CW'(mid_r);
          state_nxt = S_PROBE;
        end
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? trial_sub[7:0] : trial[7:0];
        quo_nxt  = {quo_r[6:0], trial_ge};
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.found       = hit_r;
          out_item_nxt.found_index = idx_r;
          out_item_nxt.found_row   = quo_r;
          out_item_nxt.found_col   = rem_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_w_r    <= div_w_nxt;
    step_r     <= step_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
